/* rtl/vsm_pkg.sv */
// vsm_pkg: shared types and constants for the vector softmax block
// command and status structs between controller and datapath, exp and divider constants
// no dependencies
package vsm_pkg;

    localparam logic [16:0] LOG2E_Q16    = 17'd94548;
    localparam logic [29:0] LN2_Q30      = 30'd744261118;
    localparam logic [30:0] ONE_Q30      = 31'h4000_0000;
    localparam logic [3:0]  TAYLOR_TERMS = 4'd10;
    localparam logic [5:0]  EXP_ZERO_N   = 6'd17;
    localparam logic [5:0]  DIV_STEPS    = 6'd33;

    typedef struct packed {
        logic load;
        logic exp_rd;
        logic exp_start;
        logic exp_store;
        logic div_rd;
        logic div_start;
        logic emit;
        logic clear;
        logic idx_clr;
        logic idx_inc;
    } t_cmd;

    typedef struct packed {
        logic exp_done;
        logic div_done;
        logic idx_last;
    } t_sts;

    // floor(2^31 / k) for the Horner divisors
    function automatic logic [31:0] rcp_q31(input logic [3:0] k);
        logic [31:0] r;
        unique case (k)
            4'd1:    r = 32'd2147483648;
            4'd2:    r = 32'd1073741824;
            4'd3:    r = 32'd715827882;
            4'd4:    r = 32'd536870912;
            4'd5:    r = 32'd429496729;
            4'd6:    r = 32'd357913941;
            4'd7:    r = 32'd306783378;
            4'd8:    r = 32'd268435456;
            4'd9:    r = 32'd238609294;
            4'd10:   r = 32'd214748364;
            default: r = 32'd0;
        endcase
        return r;
    endfunction

endpackage

/* rtl/vector_softmax.sv */
// vector_softmax: top level of the max-subtracted softmax block
// depends on vsm_pkg, vsm_ctrl, vsm_datapath
//
// Elements are taken one per cycle while busy is low; each is stored and the running
// maximum updated. The item with i_last set starts the computation and raises busy.
// An exp pass then runs the exp unit (ten Horner steps) once per stored element, and
// the output pass runs the 33-step serial divider once per result. Each result is
// shown for exactly one cycle with o_valid high, in element order, o_last_res on the
// final one and o_truncated on all of them when elements beyond MAX_LEN were dropped.
// The receiver cannot hold results off. busy falls in the cycle the last result
// appears, so a new vector may start right away.
module vector_softmax #(
    parameter int MAX_LEN    = 64,
    parameter int ELEM_WIDTH = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic [ELEM_WIDTH-1:0] i_element,
    input  logic                  i_last,
    output logic                  o_valid,
    output logic [15:0]           o_probability,
    output logic                  o_last_res,
    output logic                  o_truncated
);

    vsm_pkg::t_cmd cmd;
    vsm_pkg::t_sts sts;

    vsm_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_last  (i_last),
        .i_sts   (sts),
        .o_cmd   (cmd),
        .o_busy  (busy)
    );

    vsm_datapath #(
        .MAX_LEN    (MAX_LEN),
        .ELEM_WIDTH (ELEM_WIDTH)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_element     (i_element),
        .o_valid       (o_valid),
        .o_probability (o_probability),
        .o_last_res    (o_last_res),
        .o_truncated   (o_truncated)
    );

`ifndef SYNTHESIS
    a_no_result_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> !o_valid)
        else $error("result strobe right after an accepted item");

    a_result_from_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(busy))
        else $error("result strobe without a preceding busy cycle");

    a_units_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({sts.exp_done, sts.div_done}))
        else $error("exp unit and divider finished together");
`endif

endmodule

/* rtl/vsm_exp.sv */
// vsm_exp: iterative exp(-d/2048) in unsigned Q1.16 via 2^(d*log2 e)
// ten Horner steps on one shared multiplier chain
// depends on vsm_pkg
module vsm_exp (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [15:0] i_d,
    input  logic        i_big,
    output logic        o_done,
    output logic [16:0] o_x
);

    localparam logic [2:0] E_IDLE = 3'd0;
    localparam logic [2:0] E_U    = 3'd1;
    localparam logic [2:0] E_MUL  = 3'd2;
    localparam logic [2:0] E_RCP  = 3'd3;
    localparam logic [2:0] E_COR  = 3'd4;
    localparam logic [2:0] E_OUT  = 3'd5;

    logic [2:0]  r_st, n_st;
    logic        r_done, n_done;
    logic [32:0] r_y;
    logic        r_big;
    logic [29:0] r_u;
    logic [30:0] r_p;
    logic [29:0] r_m;
    logic [30:0] r_q0;
    logic [3:0]  r_k;
    logic [16:0] r_x;

    logic [32:0] y_prod;
    logic [56:0] u_prod;
    logic [60:0] m_prod;
    logic [61:0] q_prod;
    logic [34:0] qk;
    logic [34:0] rem;
    logic [30:0] q;
    logic [5:0]  n;
    logic        zero;
    logic [16:0] x;

    assign y_prod = 33'(i_d) * 33'(vsm_pkg::LOG2E_Q16);
    assign u_prod = 57'(r_y[26:0]) * 57'(vsm_pkg::LN2_Q30);
    assign m_prod = 61'(r_u) * 61'(r_p);
    assign q_prod = 62'(r_m) * 62'(vsm_pkg::rcp_q31(r_k));
    assign qk     = 35'(r_q0) * 35'(r_k);
    assign rem    = 35'(r_m) - qk;
    assign q      = (rem >= 35'(r_k)) ? r_q0 + 31'd1 : r_q0;
    assign n      = r_y[32:27];
    assign zero   = r_big || (n >= vsm_pkg::EXP_ZERO_N);
    assign x      = r_p[30:14] >> n;

    always_comb begin
        n_st   = r_st;
        n_done = 1'b0;
        unique case (r_st)
            E_IDLE: if (i_start) n_st = E_U;
            E_U:    n_st = E_MUL;
            E_MUL:  n_st = E_RCP;
            E_RCP:  n_st = E_COR;
            E_COR:  n_st = (r_k == 4'd1) ? E_OUT : E_MUL;
            E_OUT: begin
                n_st   = E_IDLE;
                n_done = 1'b1;
            end
            default: n_st = E_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st   <= E_IDLE;
            r_done <= 1'b0;
        end else begin
            r_st   <= n_st;
            r_done <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_st)
            E_IDLE: begin
                if (i_start) begin
                    r_y   <= y_prod;
                    r_big <= i_big;
                end
            end
            E_U: begin
                r_u <= u_prod[56:27];
                r_p <= vsm_pkg::ONE_Q30;
                r_k <= vsm_pkg::TAYLOR_TERMS;
            end
            E_MUL: r_m  <= m_prod[59:30];
            E_RCP: r_q0 <= q_prod[61:31];
            E_COR: begin
                r_p <= vsm_pkg::ONE_Q30 - q;
                r_k <= r_k - 4'd1;
            end
            E_OUT: r_x <= zero ? 17'd0 : x;
            default: r_x <= r_x;
        endcase
    end

    assign o_done = r_done;
    assign o_x    = r_x;

endmodule

/* rtl/vsm_div.sv */
// vsm_div: serial restoring divider, round(x * 65536 / sum) saturated to 16 bits
// one quotient bit per cycle over a 33-bit numerator
// depends on vsm_pkg
module vsm_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [16:0] i_x,
    input  logic [22:0] i_sum,
    output logic        o_done,
    output logic [15:0] o_q
);

    logic        r_run;
    logic        r_done;
    logic [5:0]  r_cnt;
    logic [32:0] r_num;
    logic [23:0] r_rem;
    logic [22:0] r_den;

    logic [24:0] t;
    logic        ge;

    assign t  = {r_rem, r_num[32]};
    assign ge = t >= 25'(r_den);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_run <= 1'b1;
                r_cnt <= vsm_pkg::DIV_STEPS;
            end else if (r_run) begin
                r_cnt <= r_cnt - 6'd1;
                if (r_cnt == 6'd1) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= {i_x, 16'd0} + 33'(i_sum[22:1]);
            r_rem <= '0;
            r_den <= i_sum;
        end else if (r_run) begin
            r_rem <= ge ? 24'(t - 25'(r_den)) : t[23:0];
            r_num <= {r_num[31:0], ge};
        end
    end

    assign o_done = r_done;
    assign o_q    = (|r_num[32:16]) ? 16'hFFFF : r_num[15:0];

endmodule

/* rtl/vsm_datapath.sv */
// vsm_datapath: element and exp stores, running max, count, sum and result register
// acts on controller commands; holds the exp unit and the divider
// depends on vsm_pkg, vsm_exp, vsm_div
module vsm_datapath #(
    parameter int MAX_LEN    = 64,
    parameter int ELEM_WIDTH = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  vsm_pkg::t_cmd         i_cmd,
    output vsm_pkg::t_sts         o_sts,
    input  logic [ELEM_WIDTH-1:0] i_element,
    output logic                  o_valid,
    output logic [15:0]           o_probability,
    output logic                  o_last_res,
    output logic                  o_truncated
);

    localparam int CW = $clog2(MAX_LEN + 1);
    localparam int AW = $clog2(MAX_LEN);
    localparam int DW = (ELEM_WIDTH + 1 > 17) ? ELEM_WIDTH + 1 : 17;
    localparam logic [ELEM_WIDTH-1:0] MOST_NEG = {1'b1, {(ELEM_WIDTH-1){1'b0}}};

    logic signed [ELEM_WIDTH-1:0] mem_elem [MAX_LEN];
    logic [16:0]                  mem_val  [MAX_LEN];

    logic signed [ELEM_WIDTH-1:0] r_max;
    logic [CW-1:0]                r_count;
    logic [22:0]                  r_sum;
    logic                         r_ovf;
    logic [CW-1:0]                r_idx;
    logic                         r_valid;
    logic signed [ELEM_WIDTH-1:0] r_rd_elem;
    logic [16:0]                  r_rd_val;
    logic [15:0]                  r_prob;
    logic                         r_last_res;
    logic                         r_trunc;

    logic                         has_room;
    logic signed [ELEM_WIDTH:0]   diff;
    logic [DW-1:0]                d_ext;
    logic                         exp_done;
    logic [16:0]                  exp_x;
    logic                         div_done;
    logic [15:0]                  div_q;
    logic                         idx_last;

    assign has_room = r_count < CW'(MAX_LEN);
    assign diff     = {r_max[ELEM_WIDTH-1], r_max} - {r_rd_elem[ELEM_WIDTH-1], r_rd_elem};
    assign d_ext    = DW'($unsigned(diff));
    assign idx_last = CW'(r_idx + 1'b1) == r_count;

    vsm_exp u_exp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.exp_start),
        .i_d     (d_ext[15:0]),
        .i_big   (|d_ext[DW-1:16]),
        .o_done  (exp_done),
        .o_x     (exp_x)
    );

    vsm_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_x     (r_rd_val),
        .i_sum   (r_sum),
        .o_done  (div_done),
        .o_q     (div_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max   <= MOST_NEG;
            r_count <= '0;
            r_sum   <= '0;
            r_ovf   <= 1'b0;
            r_idx   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_cmd.emit;
            if (i_cmd.clear) begin
                r_max   <= MOST_NEG;
                r_count <= '0;
                r_sum   <= '0;
                r_ovf   <= 1'b0;
            end else if (i_cmd.load) begin
                if (has_room) begin
                    r_count <= r_count + 1'b1;
                    if ($signed(i_element) > r_max) r_max <= i_element;
                end else begin
                    r_ovf <= 1'b1;
                end
            end else if (i_cmd.exp_store) begin
                r_sum <= r_sum + 23'(exp_x);
            end
            if (i_cmd.idx_clr) begin
                r_idx <= '0;
            end else if (i_cmd.idx_inc) begin
                r_idx <= r_idx + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load && has_room) mem_elem[r_count[AW-1:0]] <= i_element;
        if (i_cmd.exp_rd) r_rd_elem <= mem_elem[r_idx[AW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exp_store) mem_val[r_idx[AW-1:0]] <= exp_x;
        if (i_cmd.div_rd) r_rd_val <= mem_val[r_idx[AW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_prob     <= div_q;
            r_last_res <= idx_last;
            r_trunc    <= r_ovf;
        end
    end

    assign o_sts.exp_done = exp_done;
    assign o_sts.div_done = div_done;
    assign o_sts.idx_last = idx_last;

    assign o_valid       = r_valid;
    assign o_probability = r_prob;
    assign o_last_res    = r_last_res;
    assign o_truncated   = r_trunc;

endmodule

/* rtl/vsm_ctrl.sv */
// vsm_ctrl: sequencer for load, exp pass and output pass
// drives datapath commands from its status
// depends on vsm_pkg
module vsm_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic          i_last,
    input  vsm_pkg::t_sts i_sts,
    output vsm_pkg::t_cmd o_cmd,
    output logic          o_busy
);

    localparam logic [2:0] C_LOAD   = 3'd0;
    localparam logic [2:0] C_ERD    = 3'd1;
    localparam logic [2:0] C_ESTART = 3'd2;
    localparam logic [2:0] C_EWAIT  = 3'd3;
    localparam logic [2:0] C_DRD    = 3'd4;
    localparam logic [2:0] C_DSTART = 3'd5;
    localparam logic [2:0] C_DWAIT  = 3'd6;

    logic [2:0] r_st, n_st;

    always_comb begin
        n_st  = r_st;
        o_cmd = '0;
        unique case (r_st)
            C_LOAD: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    if (i_last) begin
                        o_cmd.idx_clr = 1'b1;
                        n_st          = C_ERD;
                    end
                end
            end
            C_ERD: begin
                o_cmd.exp_rd = 1'b1;
                n_st         = C_ESTART;
            end
            C_ESTART: begin
                o_cmd.exp_start = 1'b1;
                n_st            = C_EWAIT;
            end
            C_EWAIT: begin
                if (i_sts.exp_done) begin
                    o_cmd.exp_store = 1'b1;
                    if (i_sts.idx_last) begin
                        o_cmd.idx_clr = 1'b1;
                        n_st          = C_DRD;
                    end else begin
                        o_cmd.idx_inc = 1'b1;
                        n_st          = C_ERD;
                    end
                end
            end
            C_DRD: begin
                o_cmd.div_rd = 1'b1;
                n_st         = C_DSTART;
            end
            C_DSTART: begin
                o_cmd.div_start = 1'b1;
                n_st            = C_DWAIT;
            end
            C_DWAIT: begin
                if (i_sts.div_done) begin
                    o_cmd.emit = 1'b1;
                    if (i_sts.idx_last) begin
                        o_cmd.clear = 1'b1;
                        n_st        = C_LOAD;
                    end else begin
                        o_cmd.idx_inc = 1'b1;
                        n_st          = C_DRD;
                    end
                end
            end
            default: n_st = C_LOAD;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= C_LOAD;
        end else begin
            r_st <= n_st;
        end
    end

    assign o_busy = r_st != C_LOAD;

endmodule
